// File: src/mrlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlm_pkg: shared types and constants of the modem reply line matcher
// Character codes, line kinds, register indexes and the command handed from
// the front end to the delivery engine.
// ----------------------------------------------------------------------------
package mrlm_pkg;

	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_UNSOL = 2'd2;

	localparam logic [1:0] REG_EXP_LO  = 2'd0;
	localparam logic [1:0] REG_EXP_HI  = 2'd1;
	localparam logic [1:0] REG_EXP_LEN = 2'd2;

	localparam int FAIL_LEN   = 12;
	localparam int CLOSED_LEN = 6;
	localparam int WIN_LEN    = 16;
	localparam int MIN_LINE   = 4;
	localparam int UNSOL_LINE = 15;

	localparam logic [8*FAIL_LEN-1:0] FAIL_TEXT = "CONNECT FAIL";
	localparam logic [8*CLOSED_LEN-1:0] CLOSED_TEXT = "CLOSED";

	// command for the back end: a status beat, or a line drain of len bytes
	typedef struct packed {
		logic       drain;
		logic [6:0] len;
		logic [1:0] kind;
		logic       ok;
		logic       err;
		logic       cls;
		logic       prompt;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [1:0] line_kind;
		logic       last;
		logic       reply_ok;
		logic       reply_error;
		logic       link_closed;
		logic       prompt_seen;
	} res_t;

endpackage

// File: src/mrlm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlm_in_if / mrlm_out_if: valid-ready channels of the matcher
// Input carries one received byte, output carries one result beat.
// ----------------------------------------------------------------------------
interface mrlm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrlm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] line_kind;
	logic       last;
	logic       reply_ok;
	logic       reply_error;
	logic       link_closed;
	logic       prompt_seen;
	modport source (output valid, output out_byte, output byte_valid, output line_kind,
		output last, output reply_ok, output reply_error, output link_closed,
		output prompt_seen, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input line_kind,
		input last, input reply_ok, input reply_error, input link_closed,
		input prompt_seen, output ready);
endinterface

// File: src/mrlm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: src/mrlm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlm_front: byte intake and line classification
// Stores bytes in the line RAM, tracks pattern hits through a tail window and
// issues one command per byte. Takes a byte only while the back end is idle
// and the command queue is empty, since a drain reads the current line.
// ----------------------------------------------------------------------------
module mrlm_front #(
	parameter int LINE_DEPTH  = 64,
	parameter int PATTERN_MAX = 16,
	localparam int AW = $clog2(LINE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mrlm_in_if.sink              rx,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 may_take,
	output logic                 cmd_push,
	output mrlm_pkg::cmd_t       cmd,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [7:0]           ram_wdata
);
	logic [63:0] exp_lo_q, exp_hi_q;
	logic [4:0]  exp_len_q;
	logic [6:0]  count_q;
	logic [7:0]  win_q [mrlm_pkg::WIN_LEN];
	logic        exp_found_q, fail_found_q, cls_found_q;

	logic        take;
	logic [6:0]  base, cnt_n;
	logic [7:0]  c, prev;
	logic [7:0]  nw [mrlm_pkg::WIN_LEN];
	logic [127:0] pat;
	logic [4:0]  plen;
	logic        hit_exp, hit_fail, hit_cls, e_f, f_f, c_f, has_prev;

	assign take = rx.valid && rx.ready;
	assign rx.ready = may_take;
	assign c = rx.rx_byte;
	assign pat = {exp_hi_q, exp_lo_q};

	always_comb begin
		base = (count_q >= 7'(LINE_DEPTH)) ? 7'd0 : count_q;
		cnt_n = base + 7'd1;
		nw[0] = c;
		for (int i = 1; i < mrlm_pkg::WIN_LEN; i++) begin
			nw[i] = win_q[i-1];
		end
		plen = (exp_len_q > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : exp_len_q;
		hit_exp = ({2'd0, plen} <= cnt_n);
		for (int i = 0; i < mrlm_pkg::WIN_LEN; i++) begin
			if (5'(i) < plen && nw[4'(plen - 5'd1 - 5'(i))] != pat[8*i +: 8]) begin
				hit_exp = 1'b0;
			end
		end
		hit_fail = (cnt_n >= 7'(mrlm_pkg::FAIL_LEN));
		for (int i = 0; i < mrlm_pkg::FAIL_LEN; i++) begin
			if (nw[i] != mrlm_pkg::FAIL_TEXT[8*i +: 8]) hit_fail = 1'b0;
		end
		hit_cls = (cnt_n >= 7'(mrlm_pkg::CLOSED_LEN));
		for (int i = 0; i < mrlm_pkg::CLOSED_LEN; i++) begin
			if (nw[i] != mrlm_pkg::CLOSED_TEXT[8*i +: 8]) hit_cls = 1'b0;
		end
		e_f = (exp_found_q && base != 7'd0) || hit_exp;
		f_f = (fail_found_q && base != 7'd0) || hit_fail;
		c_f = (cls_found_q && base != 7'd0) || hit_cls;
		has_prev = (cnt_n >= 7'd2);
		prev = has_prev ? win_q[0] : 8'd0;
	end

	logic new_line;
	always_comb begin
		cmd = '0;
		new_line = 1'b0;
		priority if (has_prev && prev == mrlm_pkg::CH_GT && c == mrlm_pkg::CH_SP) begin
			new_line = 1'b1;
			cmd.ok = 1'b1;
			cmd.prompt = 1'b1;
		end else if (has_prev && prev == mrlm_pkg::CH_CR && c == mrlm_pkg::CH_LF) begin
			new_line = 1'b1;
			if (cnt_n >= 7'(mrlm_pkg::MIN_LINE)) begin
				if (e_f) begin
					cmd.drain = 1'b1;
					cmd.len = cnt_n;
					cmd.kind = mrlm_pkg::KIND_REPLY;
					cmd.ok = 1'b1;
				end else begin
					cmd.err = f_f;
					cmd.cls = c_f;
				end
			end
		end else if (cnt_n > 7'(mrlm_pkg::UNSOL_LINE) && prev != mrlm_pkg::CH_CR
				&& c == mrlm_pkg::CH_LF) begin
			new_line = 1'b1;
			cmd.drain = 1'b1;
			cmd.len = cnt_n;
			cmd.kind = mrlm_pkg::KIND_UNSOL;
		end
	end

	assign cmd_push = take;
	assign ram_we = take;
	assign ram_waddr = base[AW-1:0];
	assign ram_wdata = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_lo_q <= 64'd19279;
			exp_hi_q <= 64'd0;
			exp_len_q <= 5'd2;
			count_q <= '0;
			exp_found_q <= 1'b0;
			fail_found_q <= 1'b0;
			cls_found_q <= 1'b0;
			for (int i = 0; i < mrlm_pkg::WIN_LEN; i++) win_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mrlm_pkg::REG_EXP_LO:  exp_lo_q <= cfg_data;
					mrlm_pkg::REG_EXP_HI:  exp_hi_q <= cfg_data;
					mrlm_pkg::REG_EXP_LEN: exp_len_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (take) begin
				for (int i = 0; i < mrlm_pkg::WIN_LEN; i++) win_q[i] <= nw[i];
				count_q <= new_line ? 7'd0 : cnt_n;
				exp_found_q <= new_line ? 1'b0 : e_f;
				fail_found_q <= new_line ? 1'b0 : f_f;
				cls_found_q <= new_line ? 1'b0 : c_f;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 7'(LINE_DEPTH))
		else $error("line count beyond store depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.drain |-> !cmd.prompt && cmd.len >= 7'(mrlm_pkg::MIN_LINE))
		else $error("bad drain command");
	assert property (@(posedge clk) disable iff (!arst_n)
		take && new_line |=> count_q == 7'd0)
		else $error("line not restarted");
endmodule

// File: src/mrlm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlm_back: result delivery
// Pops commands from a two-entry queue; a status command gives one beat, a
// drain command reads the line RAM and gives one beat per stored byte.
// ----------------------------------------------------------------------------
module mrlm_back #(
	parameter int LINE_DEPTH = 64,
	localparam int AW = $clog2(LINE_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_push,
	input  mrlm_pkg::cmd_t cmd,
	output logic           idle,
	output logic [AW-1:0]  ram_raddr,
	input  logic [7:0]     ram_rdata,
	mrlm_out_if.source     tx
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	mrlm_pkg::cmd_t q_q [2];
	logic [1:0]     q_cnt_q;
	logic           q_rd_q, q_wr_q;
	logic [1:0]     state_q;
	mrlm_pkg::cmd_t cur_q;
	logic [6:0]     idx_q;
	logic           ov_q;
	mrlm_pkg::res_t res_q;
	mrlm_pkg::res_t res_n;
	logic           pop, fin, load;

	assign idle = (q_cnt_q == 2'd0) && (state_q == ST_IDLE) && !ov_q;
	assign pop = (state_q == ST_IDLE) && (q_cnt_q != 2'd0);
	assign ram_raddr = idx_q[AW-1:0];
	assign fin = (idx_q + 7'd1 == cur_q.len);
	assign load = (state_q == ST_SEND) && (!ov_q || tx.ready);

	assign tx.valid = ov_q;
	assign tx.out_byte = res_q.out_byte;
	assign tx.byte_valid = res_q.byte_valid;
	assign tx.line_kind = res_q.line_kind;
	assign tx.last = res_q.last;
	assign tx.reply_ok = res_q.reply_ok;
	assign tx.reply_error = res_q.reply_error;
	assign tx.link_closed = res_q.link_closed;
	assign tx.prompt_seen = res_q.prompt_seen;

	always_comb begin
		res_n = '0;
		res_n.last = !cur_q.drain || fin;
		if (cur_q.drain) begin
			res_n.out_byte = ram_rdata;
			res_n.byte_valid = 1'b1;
			res_n.line_kind = cur_q.kind;
			res_n.reply_ok = fin && cur_q.ok;
		end else begin
			res_n.reply_ok = cur_q.ok;
			res_n.reply_error = cur_q.err;
			res_n.link_closed = cur_q.cls;
			res_n.prompt_seen = cur_q.prompt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_push) q_q[q_wr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			q_rd_q <= 1'b0;
			q_wr_q <= 1'b0;
			state_q <= ST_IDLE;
			cur_q <= '0;
			idx_q <= '0;
			ov_q <= 1'b0;
			res_q <= '0;
		end else begin
			// hold the beat while the receiver stalls
			ov_q <= load || (ov_q && !tx.ready);
			if (load) res_q <= res_n;
			if (cmd_push) q_wr_q <= !q_wr_q;
			if (pop) q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(cmd_push) - 2'(pop);
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q <= q_q[q_rd_q];
						idx_q <= '0;
						state_q <= q_q[q_rd_q].drain ? ST_READ : ST_SEND;
					end
				end
				ST_READ: state_q <= ST_SEND;
				ST_SEND: begin
					if (load) begin
						if (cur_q.drain && !fin) begin
							idx_q <= idx_q + 7'd1;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_cnt_q <= 2'd2)
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.byte_valid |-> tx.line_kind != mrlm_pkg::KIND_NONE)
		else $error("byte beat without line kind");
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.last |-> !tx.reply_ok && !tx.reply_error && !tx.prompt_seen)
		else $error("flags on a non-final beat");
endmodule

// File: src/modem_reply_line_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_reply_line_matcher_unit: modem reply line matcher, top level
// Usage: bytes from the modem enter on rx (valid/ready). Each byte yields
// results on tx: a single status beat with last set, or for a delivered line
// one beat per stored byte, last on the final one, and reply_ok too for a reply.
// A status beat is loaded into the output register once its command is popped
// from the queue. A delivered line drains one beat at a time, each by a line
// RAM read, then the output register.
// The next byte is taken only once all results of the last one have been
// accepted from the output register, since a drain reads the current line.
// Config writes (cfg_we, cfg_index, cfg_data) go straight to the registers
// and are meant for idle time.
// Reset clears the line, window and flags and restores the default reply
// pattern "OK"; no clearing pass is needed.
// A stalled receiver holds the output register; rx waits until it drains.
// ----------------------------------------------------------------------------
module modem_reply_line_matcher_unit #(
	parameter int LINE_DEPTH  = 64,
	parameter int PATTERN_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	mrlm_in_if.sink     rx,
	mrlm_out_if.source  tx
);
	localparam int AW = $clog2(LINE_DEPTH);

	logic           may_take, cmd_push, ram_we, idle;
	mrlm_pkg::cmd_t cmd;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	// take a byte only when the previous one has been fully issued
	assign may_take = idle;

	mrlm_front #(.LINE_DEPTH(LINE_DEPTH), .PATTERN_MAX(PATTERN_MAX)) u_front (
		.clk, .arst_n, .rx, .cfg_we, .cfg_index, .cfg_data, .may_take,
		.cmd_push, .cmd, .ram_we, .ram_waddr, .ram_wdata
	);

	mrlm_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	mrlm_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
		.clk, .arst_n, .cmd_push, .cmd, .idle, .ram_raddr, .ram_rdata, .tx
	);
endmodule

// File: test/modem_reply_line_matcher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_reply_line_matcher_unit_test: self-checking bench of the line matcher
// Feeds modem byte streams (prompts, short and long lines, expected replies,
// CONNECT FAIL / CLOSED lines, unsolicited lines, full-store overflow) with
// random gaps and stalls, predicts every result beat and compares in order.
// ----------------------------------------------------------------------------
class line_scoreboard;
	logic [63:0] pat_lo, pat_hi;
	logic [4:0] pat_len;
	logic [7:0] store[64];
	int count;
	logic [7:0] win[16];
	bit got_expect, got_fail, got_closed;
	mrlm_pkg::res_t pending[$];
	int mismatches;

	function new();
		pat_lo = 64'd19279; pat_hi = 0; pat_len = 5'd2;
		count = 0; mismatches = 0;
		foreach (win[i]) win[i] = 0;
		clear_line();
	endfunction

	function void clear_line();
		count = 0; got_expect = 0; got_fail = 0; got_closed = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [63:0] val);
		if (idx == mrlm_pkg::REG_EXP_LO) pat_lo = val;
		else if (idx == mrlm_pkg::REG_EXP_HI) pat_hi = val;
		else if (idx == mrlm_pkg::REG_EXP_LEN) pat_len = val[4:0];
	endfunction

	function logic [7:0] pat_char(int i);
		if (i < 8) return pat_lo[8*i +: 8];
		return pat_hi[8*(i-8) +: 8];
	endfunction

	// text is packed with its first character in the top byte
	function bit tail_is(logic [8*16-1:0] text, int len);
		if (len > 16 || len > count) return 0;
		for (int i = 0; i < len; i++)
			if (win[len-1-i] != text[8*(len-1-i) +: 8]) return 0;
		return 1;
	endfunction

	function bit tail_is_pattern();
		int len;
		len = (pat_len > 16) ? 16 : pat_len;
		if (len > count) return 0;
		for (int i = 0; i < len; i++)
			if (win[len-1-i] != pat_char(i)) return 0;
		return 1;
	endfunction

	function void push_status(bit ok, bit err, bit cls, bit pr);
		mrlm_pkg::res_t r;
		r = '0; r.last = 1; r.reply_ok = ok; r.reply_error = err;
		r.link_closed = cls; r.prompt_seen = pr;
		pending.push_back(r);
	endfunction

	function void push_line(logic [1:0] kind, bit ok);
		mrlm_pkg::res_t r;
		for (int i = 0; i < count; i++) begin
			r = '0; r.out_byte = store[i]; r.byte_valid = 1; r.line_kind = kind;
			r.last = (i == count-1); r.reply_ok = (i == count-1) && ok;
			pending.push_back(r);
		end
	endfunction

	function void note_byte(logic [7:0] c);
		logic [7:0] prev;
		bit has_prev;
		if (count >= 64) clear_line();
		store[count] = c; count++;
		for (int i = 15; i > 0; i--) win[i] = win[i-1];
		win[0] = c;
		if (tail_is_pattern()) got_expect = 1;
		if (tail_is(mrlm_pkg::FAIL_TEXT, mrlm_pkg::FAIL_LEN)) got_fail = 1;
		if (tail_is(mrlm_pkg::CLOSED_TEXT, mrlm_pkg::CLOSED_LEN)) got_closed = 1;
		has_prev = count >= 2;
		prev = has_prev ? store[count-2] : 8'd0;
		if (has_prev && prev == mrlm_pkg::CH_GT && c == mrlm_pkg::CH_SP) begin
			clear_line(); push_status(1, 0, 0, 1);
		end else if (has_prev && prev == mrlm_pkg::CH_CR && c == mrlm_pkg::CH_LF) begin
			if (count < mrlm_pkg::MIN_LINE) push_status(0, 0, 0, 0);
			else if (got_expect) push_line(mrlm_pkg::KIND_REPLY, 1);
			else push_status(0, got_fail, got_closed, 0);
			clear_line();
		end else if (count > mrlm_pkg::UNSOL_LINE && prev != mrlm_pkg::CH_CR
				&& c == mrlm_pkg::CH_LF) begin
			push_line(mrlm_pkg::KIND_UNSOL, 0); clear_line();
		end else push_status(0, 0, 0, 0);
	endfunction

	function void check_beat(mrlm_pkg::res_t got);
		mrlm_pkg::res_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected beat %p", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) $display("beat mismatch: expected %p got %p", want, got);
		end
	endfunction
endclass

module modem_reply_line_matcher_unit_test;
	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	mrlm_in_if rx_ch();
	mrlm_out_if tx_ch();
	line_scoreboard sb = new();
	longint cycles = 0;
	bit hold_rx = 0;

	modem_reply_line_matcher_unit u_dut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .rx(rx_ch.sink), .tx(tx_ch.source));

	always #4 clk = ~clk;

	initial begin
		rx_ch.valid = 0; rx_ch.rx_byte = 0; tx_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// check beats and drive ready with random stalls
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (tx_ch.valid && tx_ch.ready)
				sb.check_beat({tx_ch.out_byte, tx_ch.byte_valid, tx_ch.line_kind, tx_ch.last,
					tx_ch.reply_ok, tx_ch.reply_error, tx_ch.link_closed,
					tx_ch.prompt_seen});
			if (hold_rx) tx_ch.ready <= 0;
			else if (stall_left > 0) begin
				stall_left <= stall_left - 1; tx_ch.ready <= 0;
			end else if (tx_ch.valid && tx_ch.ready || !tx_ch.ready) begin
				int n;
				n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				if (n == 0) tx_ch.ready <= 1;
				else begin
					stall_left <= n - 1; tx_ch.ready <= 0;
				end
			end
		end
	end

	// valid stays up between back-to-back bytes; drop it only before a gap
	task automatic send_byte(logic [7:0] b, bit gaps);
		int g;
		g = gaps ? $urandom_range(0, 12) : 0;
		if (g > 0) begin
			rx_ch.valid <= 0;
			repeat (g) @(posedge clk);
		end
		rx_ch.valid <= 1; rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sb.note_byte(b);
	endtask

	task automatic send_text(string s, bit gaps);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], gaps);
	endtask

	task automatic drain();
		rx_ch.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return mrlm_pkg::CH_CR;
			1: return mrlm_pkg::CH_LF;
			2: return mrlm_pkg::CH_GT;
			3: return mrlm_pkg::CH_SP;
			4, 5: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(8'h41, 8'h5A));
		endcase
	endfunction

	task automatic random_line(bit gaps);
		int len, kind;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 70) : $urandom_range(0, 20);
		kind = $urandom_range(0, 6);
		for (int i = 0; i < len; i++) send_byte(rand_byte(), gaps);
		case (kind)
			0: send_text("OK", gaps);
			1: send_text("CONNECT FAIL", gaps);
			2: send_text("CLOSED", gaps);
			3: send_text("> ", gaps);
			default: ;
		endcase
		if (kind != 3) begin
			if ($urandom_range(0, 2) != 0) send_byte(mrlm_pkg::CH_CR, gaps);
			if ($urandom_range(0, 5) != 0) send_byte(mrlm_pkg::CH_LF, gaps);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: default pattern, flags, prompt, unsolicited, zero bytes
		send_text("AT\r\n", 0);
		send_text("+OK\r\n", 0);
		send_text("CONNECT FAIL\r\n", 1);
		send_text("X CLOSED\r\n", 1);
		send_text(">", 0); send_text(" ", 0);
		send_byte(8'h00, 0); send_byte(8'hFF, 0); send_text("\r\n", 0);
		send_text("+EVENT:0123456789\n", 1);
		drain();
		// full pattern of 16, zero-length, overflow past full store
		write_reg(mrlm_pkg::REG_EXP_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(mrlm_pkg::REG_EXP_HI, 64'h0);
		write_reg(mrlm_pkg::REG_EXP_LEN, 5'd16);
		for (int i = 0; i < 8; i++) send_byte(8'hFF, 0);
		for (int i = 0; i < 8; i++) send_byte(8'h00, 0);
		send_text("\r\n", 0);
		drain();
		write_reg(mrlm_pkg::REG_EXP_LEN, 5'd31);
		for (int i = 0; i < 70; i++) send_byte(8'($urandom_range(0, 255)) | 8'h80, 0);
		send_text("\r\n", 0);
		drain();
		write_reg(mrlm_pkg::REG_EXP_LEN, 5'd0);
		send_text("HELLO\r\n", 0);
		drain();
		write_reg(mrlm_pkg::REG_EXP_LO, 64'h00_00_00_00_00_4B_4F_4F);
		write_reg(mrlm_pkg::REG_EXP_LEN, 5'd1);
		send_text("xOxx\r\n", 0);
		drain();
		// pressure: receiver holds off while bytes keep coming
		hold_rx = 1;
		fork
			begin repeat (600) @(posedge clk); hold_rx = 0; end
			send_text("O longer line here\r\n", 0);
		join
		drain();
		// random phases with different patterns
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(mrlm_pkg::REG_EXP_LO, ph == 0 ? 64'd19279 : {$urandom, $urandom});
			write_reg(mrlm_pkg::REG_EXP_HI, {$urandom, $urandom});
			write_reg(mrlm_pkg::REG_EXP_LEN, ph == 0 ? 5'd2 : 5'($urandom_range(0, 3)));
			random_line($urandom_range(0, 3) != 0);
			drain();
		end
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// File: filelist.f
src/mrlm_pkg.sv
src/mrlm_if.sv
src/mrlm_ram.sv
src/mrlm_front.sv
src/mrlm_back.sv
src/modem_reply_line_matcher_unit.sv
test/modem_reply_line_matcher_unit_test.sv
